@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RSRD_ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define RSRD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/rsrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrd_pkg
// types and constants shared by the row stream rle decoder
// ----------------------------------------------------------------------------
package rsrd_pkg;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stop_request;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] row_index;
        logic [5:0]  group_index;
        logic [15:0] pixel_a;
        logic [15:0] pixel_b;
        logic [15:0] pixel_c;
        logic [15:0] pixel_d;
        logic        last_of_row;
    } out_word_t;

    // command from front to back
    typedef struct packed {
        logic        is_event;
        logic [2:0]  kind;
        logic [15:0] pixel;
        logic [7:0]  count;
        logic        row_end;
        logic        emit;
        logic [15:0] row;
    } cmd_t;

    localparam logic [2:0] KIND_PIXELS     = 3'd0;
    localparam logic [2:0] KIND_FRAME_END  = 3'd1;
    localparam logic [2:0] KIND_STOPPED    = 3'd2;
    localparam logic [2:0] KIND_BAD_MAGIC  = 3'd3;
    localparam logic [2:0] KIND_BAD_LENGTH = 3'd4;

    localparam logic REG_VISIBLE_ROWS = 1'b0;
    localparam logic REG_MAX_PAYLOAD  = 1'b1;

    localparam logic [15:0] VISIBLE_ROWS_RESET = 16'd135;
    localparam logic [15:0] MAX_PAYLOAD_RESET  = 16'd700;

    localparam logic [15:0] ROW_END_MARK = 16'hFFFF;
    localparam logic [7:0]  RUN_LIMIT    = 8'd128;
    localparam logic [7:0]  LITERAL_BIAS = 8'd127;

    localparam logic [7:0] MAGIC_0 = 8'h53;
    localparam logic [7:0] MAGIC_1 = 8'h43;
    localparam logic [7:0] MAGIC_2 = 8'h52;
    localparam logic [7:0] MAGIC_3 = 8'h31;

    localparam int CMD_QUEUE_DEPTH = 4;

endpackage

@@ hw/rtl/rsrd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rsrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 60,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/rsrd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrd_fifo
// short command queue between the parser and the row engine
// ----------------------------------------------------------------------------
module rsrd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rsrd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output rsrd_pkg::cmd_t pop_cmd,
    output logic          full,
    output logic          empty
);
    import rsrd_pkg::*;

    localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);

    cmd_t          slots_reg [CMD_QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(CMD_QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/rsrd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrd_front
// byte parser: header check, row headers, rle tokens, pixel run commands
// ----------------------------------------------------------------------------
module rsrd_front #(
    parameter int ROW_PIXELS = 240
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rsrd_pkg::in_word_t in_word,
    input  logic [15:0]       visible_rows,
    input  logic [15:0]       max_payload_bytes,
    input  logic              queue_full,
    output logic              push,
    output rsrd_pkg::cmd_t    cmd
);
    import rsrd_pkg::*;

    localparam int PW = $clog2(ROW_PIXELS + 1);
    localparam int CW = (PW > 8) ? PW : 8;

    typedef enum logic [1:0] {PH_MAGIC, PH_HEADER, PH_PAYLOAD, PH_HALT} phase_t;

    phase_t        phase_reg, phase_next;
    logic [2:0]    hcount_reg, hcount_next;
    logic          good_reg, good_next;
    logic [15:0]   row_reg, row_next;
    logic [7:0]    len_lo_reg, len_lo_next;
    logic [15:0]   len_reg, len_next;
    logic [15:0]   pcount_reg, pcount_next;
    logic [PW-1:0] pw_reg, pw_next;
    logic          tok_open_reg, tok_open_next;
    logic [7:0]    tok_ctl_reg, tok_ctl_next;
    logic [8:0]    left_reg, left_next;
    logic [7:0]    pend_reg, pend_next;

    logic          accept;
    logic [7:0]    b;
    logic [7:0]    magic_byte;
    logic [7:0]    run_n;
    logic [CW-1:0] remaining;
    logic [CW-1:0] pix_count;
    logic          pix_evt;
    logic          row_end;
    logic [15:0]   len_full;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_word.stream_byte;
    assign len_full = {b, len_lo_reg};
    assign run_n    = (tok_ctl_reg < RUN_LIMIT) ? tok_ctl_reg + 8'd1 : 8'd1;
    assign remaining = CW'(ROW_PIXELS) - CW'(pw_reg);

    always_comb
    begin
        if (pw_reg >= PW'(ROW_PIXELS))
        begin
            pix_count = '0;
        end
        else if (CW'(run_n) > remaining)
        begin
            pix_count = remaining;
        end
        else
        begin
            pix_count = CW'(run_n);
        end
    end

    always_comb
    begin
        unique case (hcount_reg[1:0])
            2'd0:    magic_byte = MAGIC_0;
            2'd1:    magic_byte = MAGIC_1;
            2'd2:    magic_byte = MAGIC_2;
            default: magic_byte = MAGIC_3;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        hcount_next   = hcount_reg;
        good_next     = good_reg;
        row_next      = row_reg;
        len_lo_next   = len_lo_reg;
        len_next      = len_reg;
        pcount_next   = pcount_reg;
        pw_next       = pw_reg;
        tok_open_next = tok_open_reg;
        tok_ctl_next  = tok_ctl_reg;
        left_next     = left_reg;
        pend_next     = pend_reg;
        pix_evt       = 1'b0;
        row_end       = 1'b0;
        push          = 1'b0;
        cmd           = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (!hcount_reg[2] && (b != magic_byte))
                    begin
                        good_next = 1'b0;
                    end
                    hcount_next = hcount_reg + 3'd1;
                    if (hcount_reg == 3'd7)
                    begin
                        hcount_next = '0;
                        if (!good_next)
                        begin
                            push       = 1'b1;
                            cmd.is_event = 1'b1;
                            cmd.kind   = KIND_BAD_MAGIC;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                PH_HEADER:
                begin
                    hcount_next = hcount_reg + 3'd1;
                    unique case (hcount_reg[1:0])
                        2'd0:    row_next[7:0]  = b;
                        2'd1:    row_next[15:8] = b;
                        2'd2:    len_lo_next    = b;
                        default:
                        begin
                            hcount_next = '0;
                            len_next    = len_full;
                            if (row_reg == ROW_END_MARK)
                            begin
                                push         = 1'b1;
                                cmd.is_event = 1'b1;
                                if (in_word.stop_request)
                                begin
                                    cmd.kind   = KIND_STOPPED;
                                    phase_next = PH_HALT;
                                end
                                else
                                begin
                                    cmd.kind = KIND_FRAME_END;
                                end
                            end
                            else if ((len_full == '0) || (len_full > max_payload_bytes))
                            begin
                                push         = 1'b1;
                                cmd.is_event = 1'b1;
                                cmd.kind     = KIND_BAD_LENGTH;
                                phase_next   = PH_HALT;
                            end
                            else
                            begin
                                pcount_next   = '0;
                                pw_next       = '0;
                                tok_open_next = 1'b0;
                                left_next     = '0;
                                phase_next    = PH_PAYLOAD;
                            end
                        end
                    endcase
                end
                PH_PAYLOAD:
                begin
                    if (!tok_open_reg)
                    begin
                        if (pw_reg < PW'(ROW_PIXELS))
                        begin
                            tok_ctl_next  = b;
                            tok_open_next = 1'b1;
                            left_next     = (b < RUN_LIMIT) ? 9'd2 : {b - LITERAL_BIAS, 1'b0};
                        end
                    end
                    else
                    begin
                        if (!left_reg[0])
                        begin
                            pend_next = b;
                        end
                        else
                        begin
                            pix_evt = 1'b1;
                            pw_next = pw_reg + pix_count[PW-1:0];
                        end
                        left_next = left_reg - 9'd1;
                        if (left_reg == 9'd1)
                        begin
                            tok_open_next = 1'b0;
                        end
                    end
                    pcount_next = pcount_reg + 16'd1;
                    if (pcount_next == len_reg)
                    begin
                        row_end     = 1'b1;
                        cmd.emit    = !tok_open_next && (row_reg < visible_rows);
                        pcount_next = '0;
                        tok_open_next = 1'b0;
                        phase_next  = PH_HEADER;
                    end
                    cmd.row_end = row_end;
                    cmd.row     = row_reg;
                    cmd.pixel   = {b, pend_reg};
                    cmd.count   = pix_evt ? pix_count[7:0] : 8'd0;
                    push        = (pix_evt && (pix_count != '0)) || row_end;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            hcount_reg   <= '0;
            good_reg     <= 1'b1;
            row_reg      <= '0;
            len_reg      <= '0;
            pcount_reg   <= '0;
            pw_reg       <= '0;
            tok_open_reg <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hcount_reg   <= hcount_next;
            good_reg     <= good_next;
            row_reg      <= row_next;
            len_reg      <= len_next;
            pcount_reg   <= pcount_next;
            pw_reg       <= pw_next;
            tok_open_reg <= tok_open_next;
            left_reg     <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_lo_reg  <= len_lo_next;
        tok_ctl_reg <= tok_ctl_next;
        pend_reg    <= pend_next;
    end

endmodule

@@ hw/rtl/rsrd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrd_back
// row engine: writes pixel runs into banked row buffer, reads rows out
// ----------------------------------------------------------------------------
module rsrd_back #(
    parameter int ROW_PIXELS        = 240,
    parameter int PIXELS_PER_RESULT = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  rsrd_pkg::cmd_t     cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output rsrd_pkg::out_word_t out_word
);
    import rsrd_pkg::*;

    localparam int GROUPS = (ROW_PIXELS + PIXELS_PER_RESULT - 1) / PIXELS_PER_RESULT;
    localparam int GW = $clog2(GROUPS + 1);
    localparam int AW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int LW = (PIXELS_PER_RESULT > 1) ? $clog2(PIXELS_PER_RESULT) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_FILL, ST_READ, ST_SEND} state_t;

    state_t        state_reg, state_next;
    cmd_t          cur_reg, cur_next;
    logic [7:0]    fill_left_reg, fill_left_next;
    logic [LW-1:0] wr_lane_reg, wr_lane_next;
    logic [GW-1:0] wr_group_reg, wr_group_next;
    logic [GW-1:0] rd_group_reg, rd_group_next;
    logic          out_valid_reg, out_valid_next;
    out_word_t     out_word_reg, out_word_next;

    logic          we;
    logic          rd_en;
    logic          out_free;
    logic [15:0]   rd_data [PIXELS_PER_RESULT];
    logic [15:0]   px [4];

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    for (genvar j = 0; j < PIXELS_PER_RESULT; j++)
    begin : g_bank
        rsrd_ram #(
            .WIDTH (16),
            .DEPTH (GROUPS)
        ) u_ram (
            .clk     (clk),
            .we      (we && (wr_lane_reg == LW'(j))),
            .wr_addr (wr_group_reg[AW-1:0]),
            .wr_data (cur_reg.pixel),
            .rd_en   (rd_en),
            .rd_addr (rd_group_reg[AW-1:0]),
            .rd_data (rd_data[j])
        );
    end

    // never-written slots read as zero
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            px[j] = '0;
            if (j < PIXELS_PER_RESULT)
            begin
                if ((rd_group_reg < wr_group_reg) ||
                    ((rd_group_reg == wr_group_reg) && (LW'(j) < wr_lane_reg)))
                begin
                    px[j] = rd_data[j];
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        fill_left_next = fill_left_reg;
        wr_lane_next   = wr_lane_reg;
        wr_group_next  = wr_group_reg;
        rd_group_next  = rd_group_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        pop            = 1'b0;
        we             = 1'b0;
        rd_en          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_event)
                    begin
                        if (out_free)
                        begin
                            pop                       = 1'b1;
                            out_valid_next            = 1'b1;
                            out_word_next             = '0;
                            out_word_next.kind        = cmd.kind;
                            out_word_next.last_of_row = 1'b1;
                        end
                    end
                    else
                    begin
                        pop            = 1'b1;
                        cur_next       = cmd;
                        fill_left_next = cmd.count;
                        state_next     = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                if (fill_left_reg != '0)
                begin
                    we             = 1'b1;
                    fill_left_next = fill_left_reg - 8'd1;
                    if (wr_lane_reg == LW'(PIXELS_PER_RESULT - 1))
                    begin
                        wr_lane_next  = '0;
                        wr_group_next = wr_group_reg + 1'b1;
                    end
                    else
                    begin
                        wr_lane_next = wr_lane_reg + 1'b1;
                    end
                end
                else if (cur_reg.row_end && cur_reg.emit)
                begin
                    rd_group_next = '0;
                    state_next    = ST_READ;
                end
                else
                begin
                    if (cur_reg.row_end)
                    begin
                        wr_lane_next  = '0;
                        wr_group_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.kind        = KIND_PIXELS;
                    out_word_next.row_index   = cur_reg.row;
                    out_word_next.group_index = 6'(rd_group_reg);
                    out_word_next.pixel_a     = px[0];
                    out_word_next.pixel_b     = px[1];
                    out_word_next.pixel_c     = px[2];
                    out_word_next.pixel_d     = px[3];
                    out_word_next.last_of_row = (rd_group_reg == GW'(GROUPS - 1));
                    if (rd_group_reg == GW'(GROUPS - 1))
                    begin
                        wr_lane_next  = '0;
                        wr_group_next = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        rd_group_next = rd_group_reg + 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_left_reg <= '0;
            wr_lane_reg   <= '0;
            wr_group_reg  <= '0;
            rd_group_reg  <= '0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_left_reg <= fill_left_next;
            wr_lane_reg   <= wr_lane_next;
            wr_group_reg  <= wr_group_next;
            rd_group_reg  <= rd_group_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            out_word_reg  <= out_word_next;
        end
    end

endmodule

@@ hw/rtl/row_stream_rle_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_stream_rle_decoder_unit
// rle row stream decoder: bytes in, groups of rgb565 pixels and events out
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle while its four-entry command queue has
// room. A byte that completes a run pixel has the row engine write each of its
// pixels into the row buffer in turn (up to 128 for one run); a row readout
// takes each group of pixels through a ram read and then an output load, and
// the load waits while the previous output word is not taken. Ram write and
// read share the row engine, which sets the sustained rate.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module row_stream_rle_decoder_unit #(
    parameter int ROW_PIXELS        = 240,
    parameter int PIXELS_PER_RESULT = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rsrd_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output rsrd_pkg::out_word_t out_word,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);
    import rsrd_pkg::*;

    logic [15:0] visible_rows_reg, visible_rows_next;
    logic [15:0] max_payload_reg, max_payload_next;

    logic q_push, q_pop, q_full, q_empty;
    cmd_t push_cmd, pop_cmd;

    always_comb
    begin
        visible_rows_next = visible_rows_reg;
        max_payload_next  = max_payload_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VISIBLE_ROWS: visible_rows_next = cfg_data;
                REG_MAX_PAYLOAD:  max_payload_next  = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visible_rows_reg <= VISIBLE_ROWS_RESET;
            max_payload_reg  <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            visible_rows_reg <= visible_rows_next;
            max_payload_reg  <= max_payload_next;
        end
    end

    rsrd_front #(
        .ROW_PIXELS (ROW_PIXELS)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_word           (in_word),
        .visible_rows      (visible_rows_reg),
        .max_payload_bytes (max_payload_reg),
        .queue_full        (q_full),
        .push              (q_push),
        .cmd               (push_cmd)
    );

    rsrd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    rsrd_back #(
        .ROW_PIXELS        (ROW_PIXELS),
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (pop_cmd),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    `RSRD_ASSERT_IMPLIES(a_push_room, clk, rst_n, q_push, !q_full, "push into full queue")
    `RSRD_ASSERT_IMPLIES(a_pop_data, clk, rst_n, q_pop, !q_empty, "pop from empty queue")
    `RSRD_ASSERT_IMPLIES(a_push_on_word, clk, rst_n, q_push, in_valid && in_ready, "push without word")
    `RSRD_ASSERT_NEXT(a_queue_holds, clk, rst_n, q_push && !q_pop, !q_empty, "queue lost a command")
    `RSRD_ASSERT_IMPLIES(a_event_last, clk, rst_n, out_valid && (out_word.kind != KIND_PIXELS), out_word.last_of_row, "event word without last flag")

endmodule

@@ test/row_stream_rle_decoder_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_stream_rle_decoder_unit_checker
// watches the byte channel, the config port and the result channel of the
// decoder, keeps its own copy of the decoder state, predicts the result words
// for every accepted byte and compares them in order, field by field
// ----------------------------------------------------------------------------
module row_stream_rle_decoder_unit_checker
    import rsrd_pkg::*;
#(
    parameter int ROW_PIXELS = 240
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_word,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_word,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [15:0] cfg_data,
    output int        error_count,
    output int        pending_words
);

    typedef enum int {PH_MAGIC, PH_ROW_HEAD, PH_PAYLOAD} parse_phase_t;

    localparam int GROUPS = (ROW_PIXELS + 3) / 4;

    out_word_t    expected_words[$];
    logic [15:0]  visible_rows;
    logic [15:0]  max_payload;
    parse_phase_t phase;
    int           head_count;
    logic [7:0]   head_bytes[4];
    logic         magic_ok;
    logic [15:0]  cur_row;
    logic [15:0]  pay_len;
    logic [15:0]  pay_count;
    int           pix_count;
    logic         tok_open;
    logic [7:0]   tok_ctrl;
    int           operand_left;
    logic [7:0]   low_byte;
    logic [15:0]  row_pixels[ROW_PIXELS];
    logic         halted;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic push_word(input logic [2:0] kind, input logic [15:0] row,
                             input logic [5:0] grp, input logic [15:0] a,
                             input logic [15:0] b, input logic [15:0] c,
                             input logic [15:0] d, input logic last);
        out_word_t w;
        w.kind        = kind;
        w.row_index   = row;
        w.group_index = grp;
        w.pixel_a     = a;
        w.pixel_b     = b;
        w.pixel_c     = c;
        w.pixel_d     = d;
        w.last_of_row = last;
        expected_words.push_back(w);
    endtask

    function automatic logic [7:0] magic_at(input int i);
        case (i)
            0: return MAGIC_0;
            1: return MAGIC_1;
            2: return MAGIC_2;
            default: return MAGIC_3;
        endcase
    endfunction

    function automatic logic [15:0] pixel_at(input int idx);
        if (idx < ROW_PIXELS && idx < pix_count)
            return row_pixels[idx];
        return 16'h0000;
    endfunction

    task automatic store_pixel(input logic [15:0] px);
        if (pix_count < ROW_PIXELS)
        begin
            row_pixels[pix_count] = px;
            pix_count++;
        end
    endtask

    task automatic decode_payload_byte(input logic [7:0] b);
        logic [15:0] px;
        int n;
        if (!tok_open)
        begin
            if (pix_count < ROW_PIXELS)
            begin
                tok_ctrl     = b;
                tok_open     = 1'b1;
                operand_left = (b < RUN_LIMIT) ? 2 : 2 * (int'(b) - int'(LITERAL_BIAS));
            end
        end
        else
        begin
            if (operand_left % 2 == 0)
                low_byte = b;
            else
            begin
                px = {b, low_byte};
                if (tok_ctrl < RUN_LIMIT)
                begin
                    n = int'(tok_ctrl) + 1;
                    for (int k = 0; k < n; k++)
                        store_pixel(px);
                end
                else
                    store_pixel(px);
            end
            operand_left--;
            if (operand_left == 0)
                tok_open = 1'b0;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic stop);
        if (halted)
            return;
        case (phase)
            PH_MAGIC:
            begin
                if (head_count < 4 && b != magic_at(head_count))
                    magic_ok = 1'b0;
                head_count++;
                if (head_count == 8)
                begin
                    head_count = 0;
                    if (!magic_ok)
                    begin
                        halted = 1'b1;
                        push_word(KIND_BAD_MAGIC, '0, '0, '0, '0, '0, '0, 1'b1);
                    end
                    else
                        phase = PH_ROW_HEAD;
                end
            end
            PH_ROW_HEAD:
            begin
                head_bytes[head_count] = b;
                head_count++;
                if (head_count == 4)
                begin
                    head_count = 0;
                    cur_row = {head_bytes[1], head_bytes[0]};
                    pay_len = {head_bytes[3], head_bytes[2]};
                    if (cur_row == ROW_END_MARK)
                    begin
                        if (stop)
                        begin
                            halted = 1'b1;
                            push_word(KIND_STOPPED, '0, '0, '0, '0, '0, '0, 1'b1);
                        end
                        else
                            push_word(KIND_FRAME_END, '0, '0, '0, '0, '0, '0, 1'b1);
                    end
                    else if (pay_len == '0 || pay_len > max_payload)
                    begin
                        halted = 1'b1;
                        push_word(KIND_BAD_LENGTH, '0, '0, '0, '0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        pay_count    = '0;
                        pix_count    = 0;
                        tok_open     = 1'b0;
                        operand_left = 0;
                        phase        = PH_PAYLOAD;
                    end
                end
            end
            default:
            begin
                decode_payload_byte(b);
                pay_count++;
                if (pay_count == pay_len)
                begin
                    phase     = PH_ROW_HEAD;
                    pay_count = '0;
                    if (!tok_open && cur_row < visible_rows)
                        for (int g = 0; g < GROUPS; g++)
                            push_word(KIND_PIXELS, cur_row, g[5:0], pixel_at(4 * g),
                                      pixel_at(4 * g + 1), pixel_at(4 * g + 2),
                                      pixel_at(4 * g + 3), g == GROUPS - 1);
                    tok_open = 1'b0;
                end
            end
        endcase
    endtask

    task automatic check_word(input out_word_t got);
        out_word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("unexpected word, kind", 16'(got.kind), 16'h0000);
            return;
        end
        want = expected_words.pop_front();
        if (got.kind != want.kind)
            report_mismatch("kind", 16'(got.kind), 16'(want.kind));
        if (got.row_index != want.row_index)
            report_mismatch("row_index", got.row_index, want.row_index);
        if (got.group_index != want.group_index)
            report_mismatch("group_index", 16'(got.group_index), 16'(want.group_index));
        if (got.pixel_a != want.pixel_a)
            report_mismatch("pixel_a", got.pixel_a, want.pixel_a);
        if (got.pixel_b != want.pixel_b)
            report_mismatch("pixel_b", got.pixel_b, want.pixel_b);
        if (got.pixel_c != want.pixel_c)
            report_mismatch("pixel_c", got.pixel_c, want.pixel_c);
        if (got.pixel_d != want.pixel_d)
            report_mismatch("pixel_d", got.pixel_d, want.pixel_d);
        if (got.last_of_row != want.last_of_row)
            report_mismatch("last_of_row", 16'(got.last_of_row), 16'(want.last_of_row));
    endtask

    initial
    begin
        error_count   = 0;
        pending_words = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            visible_rows = VISIBLE_ROWS_RESET;
            max_payload  = MAX_PAYLOAD_RESET;
            phase        = PH_MAGIC;
            head_count   = 0;
            magic_ok     = 1'b1;
            cur_row      = '0;
            pay_len      = '0;
            pay_count    = '0;
            pix_count    = 0;
            tok_open     = 1'b0;
            operand_left = 0;
            halted       = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_VISIBLE_ROWS)
                    visible_rows = cfg_data;
                else
                    max_payload = cfg_data;
            end
            if (out_valid && out_ready)
                check_word(out_word);
            if (in_valid && in_ready)
                predict_byte(in_word.stream_byte, in_word.stop_request);
        end
        pending_words = expected_words.size();
    end

endmodule

@@ test/row_stream_rle_decoder_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_stream_rle_decoder_unit_test
// drives byte streams of rle rows into the decoder: a directed opening, then
// random rows under several register settings, ending in one halting event;
// both channels idle and stall at random, the checker gives the verdict count
// ----------------------------------------------------------------------------
module row_stream_rle_decoder_unit_test;
    import rsrd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 800;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_word;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          error_count;
    int          pending_words;
    int          cycle_count;
    logic        in_taken;
    logic        no_gaps;
    logic [15:0] cur_max;
    logic [15:0] cur_visible;
    int          sent_bytes;
    int          stall_left;
    logic [7:0]  payload[$];

    row_stream_rle_decoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    row_stream_rle_decoder_unit_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_word      (out_word),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_words (pending_words)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("row_stream_rle_decoder_unit verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic stop);
        int gap;
        in_valid <= 1'b1;
        in_word  <= '{stream_byte: b, stop_request: stop};
        do
            @(negedge clk);
        while (!in_taken);
        sent_bytes++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_row(input logic [15:0] row, input logic [15:0] len);
        send_byte(row[7:0], 1'($urandom_range(0, 1)));
        send_byte(row[15:8], 1'($urandom_range(0, 1)));
        send_byte(len[7:0], 1'($urandom_range(0, 1)));
        send_byte(len[15:8], 1'($urandom_range(0, 1)));
        foreach (payload[i])
            send_byte(payload[i], 1'($urandom_range(0, 1)));
    endtask

    task automatic add_pixel();
        payload.push_back(8'($urandom_range(0, 255)));
        payload.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_payload();
        int mode;
        int n;
        payload.delete();
        mode = $urandom_range(0, 9);
        if (mode < 2)
        begin
            // overflow past the row width, then junk after a full row
            payload.push_back(8'd127);
            add_pixel();
            payload.push_back(8'd127);
            add_pixel();
            repeat ($urandom_range(0, 5)) payload.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 1))
                begin
                    payload.push_back($urandom_range(0, 3) == 0 ? 8'd127 :
                                      8'($urandom_range(0, 127)));
                    add_pixel();
                end
                else
                begin
                    n = ($urandom_range(0, 15) == 0) ? 30 : $urandom_range(1, 4);
                    payload.push_back(8'(127 + n));
                    repeat (n) add_pixel();
                end
            end
            // cut token at the end
            if (mode == 9)
                repeat ($urandom_range(1, 2)) void'(payload.pop_back());
        end
        while (payload.size() > cur_max)
            void'(payload.pop_back());
    endtask

    function automatic logic [15:0] pick_row();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'($urandom_range(0, 250));
        if (r == 6)
            return 16'h0000;
        if (r == 7)
            return 16'hFFFE;
        if (r == 8)
            return (cur_visible == 16'h0000) ? 16'h0000 :
                   cur_visible - 16'($urandom_range(0, 1));
        return 16'($urandom_range(0, 16'hFFFE));
    endfunction

    task automatic send_frame_end(input logic stop);
        send_byte(8'hFF, 1'($urandom_range(0, 1)));
        send_byte(8'hFF, 1'($urandom_range(0, 1)));
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_byte(8'($urandom_range(0, 255)), stop);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_config(input logic [15:0] vis, input logic [15:0] maxp);
        cfg_we    <= 1'b1;
        cfg_index <= REG_VISIBLE_ROWS;
        cfg_data  <= vis;
        @(negedge clk);
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_data  <= maxp;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_visible = vis;
        cur_max     = maxp;
    endtask

    logic [15:0] vis_set[5] = '{16'd135, 16'd0, 16'd65534, 16'd60, 16'd200};
    logic [15:0] max_set[5] = '{16'd700, 16'd65535, 16'd1, 16'd12, 16'd700};

    initial
    begin
        logic bad_magic;
        int   quota;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_VISIBLE_ROWS;
        cfg_data    = '0;
        cycle_count = 0;
        in_taken    = 1'b0;
        stall_left  = 0;
        no_gaps     = 1'b0;
        sent_bytes  = 0;
        cur_visible = VISIBLE_ROWS_RESET;
        cur_max     = MAX_PAYLOAD_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // stream header, rarely with bad magic
        bad_magic = ($urandom_range(0, 5) == 0);
        send_byte(MAGIC_0, 1'b0);
        send_byte(MAGIC_1, 1'b1);
        send_byte(bad_magic ? 8'h00 : MAGIC_2, 1'b0);
        send_byte(MAGIC_3, 1'b1);
        repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);

        // run of 128, single literal, run of one, zero and all-ones pixels
        payload = '{8'd127, 8'hFF, 8'hFF, 8'd128, 8'h5A, 8'hA5, 8'd0, 8'h00, 8'h00};
        send_row(16'd2, 16'd9);
        send_frame_end(1'b0);

        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            write_config(vis_set[p], max_set[p]);
            no_gaps = (p == 3);
            quota   = sent_bytes + 10;
            while (sent_bytes < quota)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_frame_end(1'b0);
                else
                begin
                    build_payload();
                    send_row(pick_row(), 16'(payload.size()));
                end
            end
        end
        no_gaps = 1'b0;

        // one halting event closes the stream
        wait_idle();
        if ($urandom_range(0, 1))
            send_frame_end(1'b1);
        else
        begin
            payload.delete();
            send_row(pick_row(), $urandom_range(0, 1) ? 16'd0 : cur_max + 16'd1);
        end
        repeat (6) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        wait_idle();
        if (error_count == 0)
            $display("row_stream_rle_decoder_unit verification clean");
        else
            $display("row_stream_rle_decoder_unit verification failed");
        $finish;
    end

endmodule
